// ===== rtl/bss_pkg.sv =====
package bss_pkg;

    localparam int RING_DEPTH    = 4096;
    localparam int PAYLOAD_BYTES = 1024;
    localparam int HDR_BYTES     = 4;

    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int CHUNK_W = $clog2(PAYLOAD_BYTES + 1);
    localparam int POS_W   = $clog2(HDR_BYTES + PAYLOAD_BYTES + 1);
    localparam int CMP_W   = ((PTR_W > CHUNK_W) ? PTR_W : CHUNK_W) + 1;

    localparam int QUEUED_W = 12;
    localparam int TOTAL_W  = 16;
    localparam int OFFSET_W = 32;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_PULL  = 2'd2;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_FLUSH  = 2'd1;
    localparam logic [1:0] KIND_PACKET = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [7:0] FLAG_FIRST = 8'h01;
    localparam logic [7:0] FLAG_LAST  = 8'h02;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic [7:0] window_packets;
    } bss_in_t;

    typedef struct packed {
        logic [1:0]          result_kind;
        logic                write_accepted;
        logic [QUEUED_W-1:0] queued_bytes;
        logic [7:0]          packet_byte;
        logic                packet_start;
        logic                packet_end;
        logic                session_done;
        logic [TOTAL_W-1:0]  flushed_bytes;
    } bss_out_t;

    typedef struct packed {
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic [PTR_W-1:0] rd_addr;
    } bss_ring_ctrl_t;

endpackage

// ===== rtl/bss_ring.sv =====
module bss_ring (
    input  logic                    clk,
    input  bss_pkg::bss_ring_ctrl_t ctrl,
    output logic [7:0]              rd_byte
);
    import bss_pkg::*;

    logic [7:0]       mem [RING_DEPTH];
    logic [7:0]       rd_q_reg;
    logic             fwd_hit_reg;
    logic [7:0]       fwd_byte_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        rd_q_reg     <= mem[ctrl.rd_addr];
        fwd_hit_reg  <= ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr);
        fwd_byte_reg <= ctrl.wr_data;
    end

    assign rd_byte = fwd_hit_reg ? fwd_byte_reg : rd_q_reg;

endmodule

// ===== rtl/bss_engine.sv =====
module bss_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic                    cfg_data,
    input  logic                    fire,
    input  bss_pkg::bss_in_t        item,
    input  logic [7:0]              rd_byte,
    output bss_pkg::bss_ring_ctrl_t ring,
    output bss_pkg::bss_out_t       result
);
    import bss_pkg::*;

    localparam logic [PTR_W-1:0]   FULL_COUNT  = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W-1:0]   LAST_PTR    = PTR_W'(RING_DEPTH - 1);
    localparam logic [CMP_W-1:0]   PAYLOAD_CMP = CMP_W'(PAYLOAD_BYTES);
    localparam logic [CHUNK_W-1:0] PAYLOAD_LEN = CHUNK_W'(PAYLOAD_BYTES);
    localparam logic [POS_W-1:0]   HDR_POS     = POS_W'(HDR_BYTES);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [OFFSET_W-1:0] off,
                                            input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = off[31:24];
            2'd1:    b = off[23:16];
            2'd2:    b = off[15:8];
            default: b = off[7:0];
        endcase
        return b;
    endfunction

    logic [PTR_W-1:0]    rp_reg, rp_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [PTR_W-1:0]    count_reg, count_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                active_reg, active_next;
    logic                first_reg, first_next;
    logic [7:0]          credit_reg, credit_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CHUNK_W-1:0]  chunk_reg, chunk_next;
    logic                last_reg, last_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                nagle_reg, nagle_next;

    logic [CMP_W-1:0]    count_ext;
    logic                pos_zero;
    logic [CHUNK_W-1:0]  chunk_new;
    logic                last_new;
    logic [CHUNK_W-1:0]  chunk_cur;
    logic                last_cur;
    logic [POS_W-1:0]    end_pos;
    logic [7:0]          credit_dec;

    assign count_ext = CMP_W'(count_reg);
    assign pos_zero  = (pos_reg == '0);
    assign chunk_new = (count_ext > PAYLOAD_CMP) ? PAYLOAD_LEN : CHUNK_W'(count_reg);
    assign last_new  = (count_ext <= PAYLOAD_CMP);
    assign chunk_cur = pos_zero ? chunk_new : chunk_reg;
    assign last_cur  = pos_zero ? last_new : last_reg;
    assign end_pos   = HDR_POS + POS_W'(chunk_cur);
    assign credit_dec = (credit_reg != '0) ? credit_reg - 8'd1 : credit_reg;

    always_comb
    begin
        rp_next     = rp_reg;
        wp_next     = wp_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        active_next = active_reg;
        first_next  = first_reg;
        credit_next = credit_reg;
        pos_next    = pos_reg;
        chunk_next  = chunk_reg;
        last_next   = last_reg;
        total_next  = total_reg;
        nagle_next  = cfg_write ? cfg_data : nagle_reg;

        result             = '0;
        result.result_kind = KIND_NONE;
        ring.wr_en         = 1'b0;
        ring.wr_addr       = wp_reg;
        ring.wr_data       = item.data_byte;

        if (fire)
        begin
            case (item.command)
                CMD_WRITE:
                begin
                    result.result_kind = KIND_WRITE;
                    if (count_reg < FULL_COUNT)
                    begin
                        ring.wr_en            = 1'b1;
                        wp_next               = ptr_inc(wp_reg);
                        count_next            = count_reg + 1'b1;
                        result.write_accepted = 1'b1;
                    end
                end
                CMD_FLUSH:
                begin
                    result.result_kind = KIND_FLUSH;
                    if (!active_reg && count_reg != '0 && item.window_packets != '0 &&
                        !(nagle_reg && count_ext < PAYLOAD_CMP))
                    begin
                        active_next = 1'b1;
                        first_next  = 1'b1;
                        credit_next = item.window_packets;
                        pos_next    = '0;
                        total_next  = '0;
                    end
                end
                CMD_PULL:
                begin
                    if (active_reg)
                    begin
                        if (pos_zero)
                        begin
                            result.packet_start = 1'b1;
                            chunk_next          = chunk_new;
                            last_next           = last_new;
                        end
                        if (chunk_cur == '0)
                        begin
                            active_next = 1'b0;
                            pos_next    = '0;
                        end
                        else
                        begin
                            result.result_kind = KIND_PACKET;
                            if (pos_reg < HDR_POS)
                            begin
                                result.packet_byte = hdr_byte(offset_reg, pos_reg[1:0]);
                            end
                            else if (pos_reg == HDR_POS)
                            begin
                                result.packet_byte = (first_reg ? FLAG_FIRST : 8'h00) |
                                                     (last_cur ? FLAG_LAST : 8'h00);
                            end
                            else
                            begin
                                result.packet_byte = rd_byte;
                                rp_next            = ptr_inc(rp_reg);
                                count_next         = count_reg - 1'b1;
                                if (total_reg != '1)
                                begin
                                    total_next = total_reg + 1'b1;
                                end
                            end
                            if (pos_reg == end_pos)
                            begin
                                result.packet_end = 1'b1;
                                offset_next       = offset_reg + OFFSET_W'(chunk_cur);
                                first_next        = 1'b0;
                                credit_next       = credit_dec;
                                pos_next          = '0;
                                if (credit_dec == '0 || count_next == '0)
                                begin
                                    result.session_done = 1'b1;
                                    active_next         = 1'b0;
                                end
                            end
                            else
                            begin
                                pos_next = pos_reg + 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    result.result_kind = KIND_NONE;
                end
            endcase
        end

        result.queued_bytes  = QUEUED_W'(count_next);
        result.flushed_bytes = total_next;
        ring.rd_addr         = rp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg     <= '0;
            wp_reg     <= '0;
            count_reg  <= '0;
            offset_reg <= '0;
            active_reg <= 1'b0;
            first_reg  <= 1'b0;
            credit_reg <= '0;
            pos_reg    <= '0;
            chunk_reg  <= '0;
            last_reg   <= 1'b0;
            total_reg  <= '0;
            nagle_reg  <= 1'b0;
        end
        else
        begin
            rp_reg     <= rp_next;
            wp_reg     <= wp_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
            active_reg <= active_next;
            first_reg  <= first_next;
            credit_reg <= credit_next;
            pos_reg    <= pos_next;
            chunk_reg  <= chunk_next;
            last_reg   <= last_next;
            total_reg  <= total_next;
            nagle_reg  <= nagle_next;
        end
    end

endmodule

// ===== rtl/byte_stream_segmenter_core.sv =====
// Byte stream segmenter: queues application bytes and cuts them into packets.
// Input channel (in_valid / in_stall / in_word) carries one command word:
// write a byte, request a flush, or pull the next packet byte.
// Output channel (out_valid / out_stall / out_word) returns exactly one reply
// word per command word, in order.
// cfg_write / cfg_data set the Nagle hold-off bit; write it only while idle.
// A word accepted into the input register gets its reply in the output register.
// Throughput: one word per cycle unless out_stall holds the reply; every
// command is handled by one pass of the state logic between the two registers.
// Payload bytes come from a single-port-write, single-port-read ring memory
// read ahead at the next read pointer, with bypass of a byte written to the slot being read.
// Reset clears all pointers, counters and the session; ring contents stay
// undefined and are never returned before being written.
// When out_stall is high the reply holds in the output register and one more
// word may be taken into the input register; in_stall then rises until the
// reply is taken.
module byte_stream_segmenter_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bss_pkg::bss_in_t  in_word,
    output logic              out_valid,
    input  logic              out_stall,
    output bss_pkg::bss_out_t out_word,
    input  logic              cfg_write,
    input  logic              cfg_data
);
    import bss_pkg::*;

    logic           in_full_reg, in_full_next;
    bss_in_t        in_word_reg;
    logic           out_valid_reg, out_valid_next;
    bss_out_t       out_word_reg;

    logic           out_free;
    logic           fire;
    logic           accept;
    bss_ring_ctrl_t ring_ctrl;
    logic [7:0]     rd_byte;
    bss_out_t       result;

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_full_reg && out_free;
    assign in_stall = in_full_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign in_full_next   = accept ? 1'b1 : (fire ? 1'b0 : in_full_reg);
    assign out_valid_next = fire ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    bss_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (in_word_reg),
        .rd_byte   (rd_byte),
        .ring      (ring_ctrl),
        .result    (result)
    );

    bss_ring u_ring (
        .clk     (clk),
        .ctrl    (ring_ctrl),
        .rd_byte (rd_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= in_word;
        end
        if (fire)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

`ifndef NO_ASSERTIONS
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_full_reg && out_valid && out_stall))
        else $error("input stalled without a blocked reply");

    a_done_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.session_done) |->
        (out_word.packet_end && out_word.result_kind == KIND_PACKET))
        else $error("session end not on last packet byte");

    a_accept_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.write_accepted) |-> (out_word.result_kind == KIND_WRITE))
        else $error("write accepted on a non-write reply");

    a_reply_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("processed word gave no reply");
`endif

endmodule

// ===== tb/byte_stream_segmenter_core_tb.sv =====
`timescale 1ns / 1ps

module byte_stream_segmenter_core_tb;

    import bss_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] data;
        logic [7:0] win;
        bit         typed;
        bss_out_t   reply;
    } seg_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    bss_in_t  in_word = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    bss_out_t out_word;
    logic     cfg_write = 1'b0;
    logic     cfg_data = 1'b0;

    // segmenter state as predicted
    logic [7:0]       ring_mem [RING_DEPTH];
    logic [PTR_W-1:0] rd_ptr = '0;
    logic [PTR_W-1:0] wr_ptr = '0;
    logic [31:0]      seg_offset = '0;
    bit               sess_on = 1'b0;
    bit               sess_first = 1'b0;
    bit               sess_last = 1'b0;
    logic [7:0]       credit = '0;
    int unsigned      pos = 0;
    int unsigned      chunk = 0;
    logic [15:0]      sent_payload = '0;
    bit               nagle_on = 1'b0;

    bss_out_t pending_replies [$];
    bss_out_t head_reply;
    seg_row_t seg_rows [$];

    int words_sent = 0;
    int replies_checked = 0;
    int errors = 0;
    int sessions_opened = 0;
    int packets_closed = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int phase_end;
    int hold_at;

    byte_stream_segmenter_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int unsigned ring_fill();
        logic [PTR_W-1:0] d;
        d = wr_ptr - rd_ptr;
        return int'(d);
    endfunction

    function automatic bss_out_t segment_step(input bss_in_t w);
        bss_out_t r;
        int unsigned fill;
        r = '0;
        r.result_kind = KIND_NONE;
        fill = ring_fill();
        case (w.command)
            CMD_WRITE:
            begin
                r.result_kind = KIND_WRITE;
                if (fill < RING_DEPTH - 1)
                begin
                    ring_mem[wr_ptr] = w.data_byte;
                    wr_ptr = wr_ptr + 1'b1;
                    r.write_accepted = 1'b1;
                end
            end
            CMD_FLUSH:
            begin
                r.result_kind = KIND_FLUSH;
                if (!sess_on && fill != 0 && w.window_packets != 0 &&
                    !(nagle_on && fill < PAYLOAD_BYTES))
                begin
                    sess_on = 1'b1;
                    sess_first = 1'b1;
                    credit = w.window_packets;
                    pos = 0;
                    sent_payload = '0;
                    sessions_opened++;
                end
            end
            CMD_PULL:
            begin
                if (sess_on)
                begin
                    if (pos == 0)
                    begin
                        chunk = (fill > PAYLOAD_BYTES) ? PAYLOAD_BYTES : fill;
                        sess_last = (fill <= PAYLOAD_BYTES);
                        r.packet_start = 1'b1;
                    end
                    if (chunk == 0)
                    begin
                        sess_on = 1'b0;
                        pos = 0;
                    end
                    else
                    begin
                        r.result_kind = KIND_PACKET;
                        if (pos < HDR_BYTES)
                            r.packet_byte = 8'(seg_offset >> (8 * (HDR_BYTES - 1 - pos)));
                        else if (pos == HDR_BYTES)
                            r.packet_byte = (sess_first ? FLAG_FIRST : 8'h00) |
                                            (sess_last ? FLAG_LAST : 8'h00);
                        else
                        begin
                            r.packet_byte = ring_mem[rd_ptr];
                            rd_ptr = rd_ptr + 1'b1;
                            if (sent_payload != 16'hFFFF)
                                sent_payload = sent_payload + 1'b1;
                        end
                        if (pos == HDR_BYTES + chunk)
                        begin
                            r.packet_end = 1'b1;
                            seg_offset = seg_offset + chunk;
                            sess_first = 1'b0;
                            if (credit != 0)
                                credit = credit - 1'b1;
                            pos = 0;
                            packets_closed++;
                            if (credit == 0 || ring_fill() == 0)
                            begin
                                r.session_done = 1'b1;
                                sess_on = 1'b0;
                            end
                        end
                        else
                        begin
                            pos++;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.queued_bytes = QUEUED_W'(ring_fill());
        r.flushed_bytes = sent_payload;
        return r;
    endfunction

    function automatic bss_out_t plain_reply(input logic [1:0] kind, input logic acc,
                                             input int unsigned queued);
        bss_out_t r;
        r = '0;
        r.result_kind = kind;
        r.write_accepted = acc;
        r.queued_bytes = QUEUED_W'(queued);
        return r;
    endfunction

    function automatic bit reply_differs(input bss_out_t a, input bss_out_t b);
        return (a.result_kind !== b.result_kind) || (a.write_accepted !== b.write_accepted) ||
               (a.queued_bytes !== b.queued_bytes) || (a.packet_byte !== b.packet_byte) ||
               (a.packet_start !== b.packet_start) || (a.packet_end !== b.packet_end) ||
               (a.session_done !== b.session_done) || (a.flushed_bytes !== b.flushed_bytes);
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input logic [7:0] data,
                                    input logic [7:0] win, input bit typed,
                                    input bss_out_t reply);
        seg_row_t row;
        row.cmd = cmd;
        row.data = data;
        row.win = win;
        row.typed = typed;
        row.reply = reply;
        seg_rows.push_back(row);
    endfunction

    task automatic send_word(input bss_in_t w, input bit typed, input bss_out_t typed_reply);
        bss_out_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = segment_step(w);
        pending_replies.push_back(typed ? typed_reply : predicted);
        words_sent++;
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input int unsigned win);
        bss_in_t w;
        w.command = cmd;
        w.data_byte = 8'($urandom_range(255));
        w.window_packets = 8'(win);
        send_word(w, 1'b0, '0);
    endtask

    task automatic await_replies();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_nagle(input logic value);
        await_replies();
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        nagle_on = value;
    endtask

    task automatic run_burst();
        int n;
        int pick;
        int unsigned win;
        n = $urandom_range(24);
        repeat (n) send_cmd(CMD_WRITE, $urandom_range(255));
        if ($urandom_range(11) != 0)
        begin
            if ($urandom_range(9) == 0)
                win = 0;
            else if ($urandom_range(4) == 0)
                win = $urandom_range(255, 1);
            else
                win = $urandom_range(3, 1);
            send_cmd(CMD_FLUSH, win);
        end
        while (sess_on)
        begin
            pick = $urandom_range(99);
            if (pick < 84)
                send_cmd(CMD_PULL, $urandom_range(255));
            else if (pick < 90)
                send_cmd(CMD_WRITE, $urandom_range(255));
            else if (pick < 94)
                send_cmd(CMD_FLUSH, $urandom_range(255));
            else if (pick < 97)
                send_cmd(CMD_UNUSED, $urandom_range(255));
            else
                send_cmd(CMD_PULL, $urandom_range(255));
        end
        if ($urandom_range(3) == 0)
            send_cmd($urandom_range(1) ? CMD_PULL : CMD_UNUSED, $urandom_range(255));
    endtask

    always @(posedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            replies_checked++;
            if (pending_replies.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("reply word with nothing pending: kind %0d byte %02h",
                             out_word.result_kind, out_word.packet_byte);
            end
            else
            begin
                head_reply = pending_replies.pop_front();
                if (reply_differs(head_reply, out_word))
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch exp: kind %0d acc %0d q %0d byte %02h s%0d e%0d d%0d tot %0d",
                                 head_reply.result_kind, head_reply.write_accepted,
                                 head_reply.queued_bytes, head_reply.packet_byte,
                                 head_reply.packet_start, head_reply.packet_end,
                                 head_reply.session_done, head_reply.flushed_bytes);
                        $display("         got: kind %0d acc %0d q %0d byte %02h s%0d e%0d d%0d tot %0d",
                                 out_word.result_kind, out_word.write_accepted,
                                 out_word.queued_bytes, out_word.packet_byte,
                                 out_word.packet_start, out_word.packet_end,
                                 out_word.session_done, out_word.flushed_bytes);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: %0d replies still pending", pending_replies.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(CMD_PULL,   8'h00, 8'h00, 1'b1, plain_reply(KIND_NONE, 1'b0, 0));
        add_row(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1, plain_reply(KIND_NONE, 1'b0, 0));
        add_row(CMD_FLUSH,  8'h00, 8'h08, 1'b1, plain_reply(KIND_FLUSH, 1'b0, 0));
        add_row(CMD_WRITE,  8'h00, 8'h00, 1'b1, plain_reply(KIND_WRITE, 1'b1, 1));
        add_row(CMD_WRITE,  8'hFF, 8'hFF, 1'b1, plain_reply(KIND_WRITE, 1'b1, 2));
        add_row(CMD_FLUSH,  8'h00, 8'h00, 1'b1, plain_reply(KIND_FLUSH, 1'b0, 2));
        add_row(CMD_FLUSH,  8'h00, 8'hFF, 1'b0, '0);
        add_row(CMD_FLUSH,  8'h00, 8'h01, 1'b0, '0);
        repeat (7) add_row(CMD_PULL, 8'h00, 8'h00, 1'b0, '0);
        add_row(CMD_WRITE,  8'hA5, 8'h00, 1'b0, '0);
        add_row(CMD_WRITE,  8'h5A, 8'h00, 1'b0, '0);
        add_row(CMD_FLUSH,  8'h00, 8'h01, 1'b0, '0);
        add_row(CMD_PULL,   8'h00, 8'h00, 1'b0, '0);
        add_row(CMD_WRITE,  8'h3C, 8'h00, 1'b0, '0);
        repeat (6) add_row(CMD_PULL, 8'h00, 8'h00, 1'b0, '0);

        foreach (seg_rows[i])
            send_word('{command: seg_rows[i].cmd, data_byte: seg_rows[i].data,
                        window_packets: seg_rows[i].win},
                      seg_rows[i].typed, seg_rows[i].reply);
        await_replies();

        send_idle_pct = 83;
        phase_end = words_sent + 200;
        while (words_sent < phase_end)
            run_burst();

        send_idle_pct = 0;
        recv_stall_pct <= 83;
        set_nagle(1'b1);
        phase_end = words_sent + 220;
        while (words_sent < phase_end)
            run_burst();

        send_idle_pct = 23;
        recv_stall_pct <= 23;
        set_nagle(1'b0);
        hold_at = words_sent + 100;
        phase_end = words_sent + 280;
        while (words_sent < hold_at)
            run_burst();
        // hold the output while words keep coming
        hold_reqs <= hold_reqs + 1;
        while (words_sent < phase_end)
            run_burst();

        send_idle_pct = 0;
        recv_stall_pct <= 0;
        set_nagle(1'b1);
        // queue one byte short of a payload, then one more to release the hold
        while (ring_fill() < PAYLOAD_BYTES - 1)
            send_cmd(CMD_WRITE, $urandom_range(255));
        send_cmd(CMD_FLUSH, 8'h02);
        send_cmd(CMD_WRITE, $urandom_range(255));
        send_cmd(CMD_FLUSH, 8'h02);
        repeat (8) send_cmd(CMD_PULL, $urandom_range(255));

        await_replies();
        repeat (8) @(posedge clk);
        if (pending_replies.size() != 0)
            errors++;

        $display("run: %0d command words, %0d replies checked, %0d mismatches",
                 words_sent, replies_checked, errors);
        $display("covered %0d sessions, %0d packets, Nagle hold and release, long output stall",
                 sessions_opened, packets_closed);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bss_pkg.sv
rtl/bss_ring.sv
rtl/bss_engine.sv
rtl/byte_stream_segmenter_core.sv
tb/byte_stream_segmenter_core_tb.sv
